[design/qdr_pkg.sv]
package qdr_pkg;

    // Left shift applied to the accumulator before the bias add
    localparam int unsigned BIAS_SHIFT = 8;

    // Width of a rounding shift amount (largest is 31 + BIAS_SHIFT)
    localparam int unsigned SHIFT_W = 6;

    // Operating mode codes
    localparam logic [1:0] MODE_PLAIN    = 2'd0;
    localparam logic [1:0] MODE_PRELU    = 2'd1;
    localparam logic [1:0] MODE_RESIDUAL = 2'd2;

    // Output clamp limits
    localparam logic signed [63:0] OUT_MAX = 64'sd127;
    localparam logic signed [63:0] OUT_MIN = -64'sd128;

endpackage

[design/quantized_dot_requant.sv]
// A word without last_term goes through the accept and multiply-accumulate steps.
// A word with last_term goes on through the bias, requantize and output steps; in
// residual mode, or in PReLU mode with a negative value, the residual or PReLU steps
// come first. The output step waits until the previous result is taken. No new word is
// taken until idle; all steps share one 33x33 multiplier and one 64-bit adder.
// Reset: aresetn, synchronous, active low; clears sequencer, mode, accumulator, m_valid.
module quantized_dot_requant (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [7:0]  s_act_value,
    input  logic signed [7:0]  s_weight_value,
    input  logic               s_last_term,
    input  logic signed [47:0] s_channel_bias,
    input  logic signed [31:0] s_out_mult,
    input  logic [4:0]         s_out_shift,
    input  logic signed [7:0]  s_out_zero_point,
    input  logic signed [31:0] s_alt_mult,
    input  logic [4:0]         s_alt_shift,
    input  logic signed [7:0]  s_residual_zero_point,
    input  logic signed [7:0]  s_residual_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [7:0]  m_out_value
);

    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_MAC  = 4'd1;
    localparam logic [3:0] ST_BIAS = 4'd2;
    localparam logic [3:0] ST_RMUL = 4'd3;
    localparam logic [3:0] ST_RRND = 4'd4;
    localparam logic [3:0] ST_RADD = 4'd5;
    localparam logic [3:0] ST_PLO  = 4'd6;
    localparam logic [3:0] ST_PHI  = 4'd7;
    localparam logic [3:0] ST_PRND = 4'd8;
    localparam logic [3:0] ST_QLO  = 4'd9;
    localparam logic [3:0] ST_QHI  = 4'd10;
    localparam logic [3:0] ST_QRND = 4'd11;
    localparam logic [3:0] ST_OUT  = 4'd12;

    typedef logic [qdr_pkg::SHIFT_W-1:0] shamt_t;

    logic [3:0]         state_reg, state_next;
    logic [1:0]         mode_reg;
    logic [31:0]        acc_reg, acc_next;
    logic [63:0]        work_reg, work_next;
    logic [63:0]        tmp_reg, tmp_next;
    logic signed [7:0]  out_reg, out_next;
    logic               m_valid_reg, m_valid_next;

    // Captured word
    logic signed [7:0]  act_reg, wgt_reg, ozp_reg, rzp_reg, res_reg;
    logic               last_reg;
    logic signed [47:0] bias_reg;
    logic signed [31:0] omult_reg, amult_reg;
    logic [4:0]         oshift_reg, ashift_reg;

    // Shared units
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [63:0]        add_a, add_b, add_sum;
    shamt_t             rnd_sh;
    logic [63:0]        rnd_inc;
    logic [63:0]        rnd_out;
    logic signed [8:0]  centered;
    logic               s_accept;

    assign s_ready     = (state_reg == ST_IDLE);
    assign s_accept    = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_out_value = out_reg;

    // Shared multiplier and adder
    assign mul_p   = mul_a * mul_b;
    assign add_sum = add_a + add_b;

    // Round half up: add half an LSB, then shift arithmetically
    assign rnd_sh  = (state_reg == ST_QRND)
                   ? (shamt_t'(oshift_reg) + shamt_t'(qdr_pkg::BIAS_SHIFT))
                   : shamt_t'(ashift_reg);
    assign rnd_inc = (rnd_sh == '0) ? 64'd0 : (64'd1 << (rnd_sh - shamt_t'(1)));
    assign rnd_out = 64'($signed(add_sum) >>> rnd_sh);

    assign centered = 9'(res_reg) + 9'(rzp_reg);

    // Select operands and sequence the steps
    always_comb begin
        state_next   = state_reg;
        acc_next     = acc_reg;
        work_next    = work_reg;
        tmp_next     = tmp_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg;
        mul_a        = '0;
        mul_b        = '0;
        add_a        = '0;
        add_b        = '0;

        // drop the result once taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                mul_a      = 33'(act_reg);
                mul_b      = 33'(wgt_reg);
                add_a      = {32'd0, acc_reg};
                add_b      = mul_p[63:0];
                acc_next   = add_sum[31:0];
                state_next = last_reg ? ST_BIAS : ST_IDLE;
            end
            ST_BIAS: begin
                add_a     = {{32{acc_reg[31]}}, acc_reg} << qdr_pkg::BIAS_SHIFT;
                add_b     = 64'(bias_reg);
                work_next = add_sum;
                acc_next  = '0;
                if (mode_reg == qdr_pkg::MODE_RESIDUAL) begin
                    state_next = ST_RMUL;
                end else if (mode_reg == qdr_pkg::MODE_PRELU && add_sum[63]) begin
                    state_next = ST_PLO;
                end else begin
                    state_next = ST_QLO;
                end
            end
            ST_RMUL: begin
                mul_a      = 33'(centered);
                mul_b      = 33'(amult_reg);
                tmp_next   = mul_p[63:0];
                state_next = ST_RRND;
            end
            ST_RRND: begin
                add_a      = tmp_reg;
                add_b      = rnd_inc;
                tmp_next   = rnd_out;
                state_next = ST_RADD;
            end
            ST_RADD: begin
                add_a      = work_reg;
                add_b      = tmp_reg << qdr_pkg::BIAS_SHIFT;
                work_next  = add_sum;
                state_next = ST_QLO;
            end
            ST_PLO: begin
                mul_a      = {1'b0, work_reg[31:0]};
                mul_b      = 33'(amult_reg);
                tmp_next   = mul_p[63:0];
                state_next = ST_PHI;
            end
            ST_PHI: begin
                mul_a      = 33'($signed(work_reg[63:32]));
                mul_b      = 33'(amult_reg);
                add_a      = tmp_reg;
                add_b      = {mul_p[31:0], 32'd0};
                tmp_next   = add_sum;
                state_next = ST_PRND;
            end
            ST_PRND: begin
                add_a      = tmp_reg;
                add_b      = rnd_inc;
                work_next  = rnd_out;
                state_next = ST_QLO;
            end
            ST_QLO: begin
                mul_a      = {1'b0, work_reg[31:0]};
                mul_b      = 33'(omult_reg);
                tmp_next   = mul_p[63:0];
                state_next = ST_QHI;
            end
            ST_QHI: begin
                mul_a      = 33'($signed(work_reg[63:32]));
                mul_b      = 33'(omult_reg);
                add_a      = tmp_reg;
                add_b      = {mul_p[31:0], 32'd0};
                tmp_next   = add_sum;
                state_next = ST_QRND;
            end
            ST_QRND: begin
                add_a      = tmp_reg;
                add_b      = rnd_inc;
                work_next  = rnd_out;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                // add zero point, clamp, and hold until the output register frees
                add_a = work_reg;
                add_b = 64'(ozp_reg);
                if (!m_valid_reg || m_ready) begin
                    if ($signed(add_sum) > qdr_pkg::OUT_MAX) begin
                        out_next = 8'sd127;
                    end else if ($signed(add_sum) < qdr_pkg::OUT_MIN) begin
                        out_next = -8'sd128;
                    end else begin
                        out_next = add_sum[7:0];
                    end
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= qdr_pkg::MODE_PLAIN;
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we) begin
                mode_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        work_reg <= work_next;
        tmp_reg  <= tmp_next;
        out_reg  <= out_next;
        if (s_accept) begin
            act_reg    <= s_act_value;
            wgt_reg    <= s_weight_value;
            last_reg   <= s_last_term;
            bias_reg   <= s_channel_bias;
            omult_reg  <= s_out_mult;
            oshift_reg <= s_out_shift;
            ozp_reg    <= s_out_zero_point;
            amult_reg  <= s_alt_mult;
            ashift_reg <= s_alt_shift;
            rzp_reg    <= s_residual_zero_point;
            res_reg    <= s_residual_value;
        end
    end

    // Every accepted word goes through the multiply-accumulate step
    a_accept_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> state_reg == ST_MAC)
        else $error("accepted word did not enter the MAC step");

    // A result appears only from the output step
    a_valid_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("output valid rose outside the output step");

    // Accumulator is cleared once consumed by the bias step
    a_acc_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_BIAS |=> acc_reg == 32'd0)
        else $error("accumulator not cleared after bias step");

    // The PReLU path runs only on a negative value
    a_prelu_neg: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_PLO |-> work_reg[63])
        else $error("PReLU scaling on a non-negative value");

endmodule

[dv/quantized_dot_requant_check.sv]
`timescale 1ns / 100ps
module quantized_dot_requant_check (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic signed [7:0]  s_act_value,
    input  logic signed [7:0]  s_weight_value,
    input  logic               s_last_term,
    input  logic signed [47:0] s_channel_bias,
    input  logic signed [31:0] s_out_mult,
    input  logic [4:0]         s_out_shift,
    input  logic signed [7:0]  s_out_zero_point,
    input  logic signed [31:0] s_alt_mult,
    input  logic [4:0]         s_alt_shift,
    input  logic signed [7:0]  s_residual_zero_point,
    input  logic signed [7:0]  s_residual_value,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic signed [7:0]  m_out_value,
    output int                 mismatch_count,
    output int                 results_due
);

    logic [1:0]         mode_q;
    logic signed [31:0] dot_sum;
    logic signed [7:0]  expected_bytes[$];

    // Round half up: add half an LSB, then shift arithmetically
    function automatic longint round_asr(longint v, int unsigned s);
        if (s == 0) begin
            return v;
        end
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    // Requantize a finished dot product into one int8 output byte
    function automatic logic signed [7:0] requantize(
        logic [1:0]         mode,
        logic signed [31:0] sum,
        logic signed [47:0] bias,
        logic signed [31:0] out_mult,
        logic [4:0]         out_shift,
        logic signed [7:0]  out_zp,
        logic signed [31:0] alt_mult,
        logic [4:0]         alt_shift,
        logic signed [7:0]  res_zp,
        logic signed [7:0]  res_value
    );
        longint work;
        longint centered;
        longint scaled;
        work = (longint'(sum) <<< qdr_pkg::BIAS_SHIFT) + longint'(bias);
        if (mode == qdr_pkg::MODE_RESIDUAL) begin
            centered = longint'(res_value) + longint'(res_zp);
            scaled = round_asr(centered * longint'(alt_mult), alt_shift);
            work = work + (scaled <<< qdr_pkg::BIAS_SHIFT);
        end else if (mode == qdr_pkg::MODE_PRELU && work < 0) begin
            work = round_asr(work * longint'(alt_mult), alt_shift);
        end
        work = round_asr(work * longint'(out_mult), out_shift + qdr_pkg::BIAS_SHIFT);
        work = work + longint'(out_zp);
        if (work > qdr_pkg::OUT_MAX) begin
            return 8'sd127;
        end else if (work < qdr_pkg::OUT_MIN) begin
            return -8'sd128;
        end
        return work[7:0];
    endfunction

    // Watch both channels: compare results, track mode, predict on each last word
    always @(posedge aclk) begin
        logic signed [7:0] want;
        if (!aresetn) begin
            mode_q = qdr_pkg::MODE_PLAIN;
            dot_sum = '0;
            expected_bytes.delete();
            mismatch_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_bytes.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("%0t: unexpected result %0d", $realtime, m_out_value);
                    end
                    mismatch_count++;
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_out_value !== want) begin
                        if (mismatch_count < 10) begin
                            $display("%0t: out_value expected %0d got %0d",
                                     $realtime, want, m_out_value);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (cfg_we) begin
                mode_q = cfg_wdata;
            end
            if (s_valid && s_ready) begin
                dot_sum = dot_sum + s_act_value * s_weight_value;
                if (s_last_term) begin
                    expected_bytes.push_back(requantize(
                        mode_q, dot_sum, s_channel_bias, s_out_mult, s_out_shift,
                        s_out_zero_point, s_alt_mult, s_alt_shift,
                        s_residual_zero_point, s_residual_value));
                    dot_sum = '0;
                end
            end
        end
        results_due = expected_bytes.size();
    end

endmodule

[dv/quantized_dot_requant_test.sv]
`timescale 1ns / 100ps
module quantized_dot_requant_test;

    // Code 3 is not named by the block; it behaves as plain mode
    localparam logic [1:0] MODE_SPARE = 2'd3;
    localparam int PHASES = 8;
    localparam int WORDS_PER_PHASE = 150;
    localparam int LONG_TERMS = 64;

    typedef struct {
        logic signed [7:0]  act;
        logic signed [7:0]  wgt;
        logic               last;
        logic signed [47:0] bias;
        logic signed [31:0] omul;
        logic [4:0]         osh;
        logic signed [7:0]  ozp;
        logic signed [31:0] amul;
        logic [4:0]         ash;
        logic signed [7:0]  rzp;
        logic signed [7:0]  rv;
    } mac_word_t;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [1:0]         cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic signed [7:0]  s_act_value;
    logic signed [7:0]  s_weight_value;
    logic               s_last_term;
    logic signed [47:0] s_channel_bias;
    logic signed [31:0] s_out_mult;
    logic [4:0]         s_out_shift;
    logic signed [7:0]  s_out_zero_point;
    logic signed [31:0] s_alt_mult;
    logic [4:0]         s_alt_shift;
    logic signed [7:0]  s_residual_zero_point;
    logic signed [7:0]  s_residual_value;
    logic               m_valid;
    logic               m_ready;
    logic signed [7:0]  m_out_value;

    int mismatch_count;
    int results_due;
    bit gaps_on = 1'b1;
    bit hold_request = 1'b0;

    logic [1:0] phase_modes [PHASES] = '{qdr_pkg::MODE_PRELU, qdr_pkg::MODE_RESIDUAL,
                                         qdr_pkg::MODE_PLAIN, MODE_SPARE,
                                         qdr_pkg::MODE_RESIDUAL, qdr_pkg::MODE_PRELU,
                                         qdr_pkg::MODE_PLAIN, qdr_pkg::MODE_RESIDUAL};

    quantized_dot_requant i_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_act_value           (s_act_value),
        .s_weight_value        (s_weight_value),
        .s_last_term           (s_last_term),
        .s_channel_bias        (s_channel_bias),
        .s_out_mult            (s_out_mult),
        .s_out_shift           (s_out_shift),
        .s_out_zero_point      (s_out_zero_point),
        .s_alt_mult            (s_alt_mult),
        .s_alt_shift           (s_alt_shift),
        .s_residual_zero_point (s_residual_zero_point),
        .s_residual_value      (s_residual_value),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_out_value           (m_out_value)
    );

    quantized_dot_requant_check i_check (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_we                (cfg_we),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_act_value           (s_act_value),
        .s_weight_value        (s_weight_value),
        .s_last_term           (s_last_term),
        .s_channel_bias        (s_channel_bias),
        .s_out_mult            (s_out_mult),
        .s_out_shift           (s_out_shift),
        .s_out_zero_point      (s_out_zero_point),
        .s_alt_mult            (s_alt_mult),
        .s_alt_shift           (s_alt_shift),
        .s_residual_zero_point (s_residual_zero_point),
        .s_residual_value      (s_residual_value),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_out_value           (m_out_value),
        .mismatch_count        (mismatch_count),
        .results_due           (results_due)
    );

    // 8 ns clock
    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 60) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Random magnitude: shift a random value down by a random amount
    function automatic logic signed [31:0] scaled32();
        logic signed [31:0] v;
        v = $urandom;
        return v >>> $urandom_range(0, 31);
    endfunction

    function automatic logic signed [47:0] scaled48();
        logic signed [47:0] v;
        v = 48'({$urandom, $urandom});
        return v >>> $urandom_range(0, 47);
    endfunction

    function automatic mac_word_t random_word(logic last);
        mac_word_t w;
        w.act  = 8'($urandom);
        w.wgt  = 8'($urandom);
        w.last = last;
        w.bias = scaled48();
        w.omul = scaled32();
        w.osh  = 5'($urandom);
        w.ozp  = 8'($urandom);
        w.amul = scaled32();
        w.ash  = 5'($urandom);
        w.rzp  = 8'($urandom);
        w.rv   = 8'($urandom);
        return w;
    endfunction

    // Offer one word, hold it until accepted, then maybe idle
    task automatic send_word(mac_word_t w);
        int gap;
        s_act_value           <= w.act;
        s_weight_value        <= w.wgt;
        s_last_term           <= w.last;
        s_channel_bias        <= w.bias;
        s_out_mult            <= w.omul;
        s_out_shift           <= w.osh;
        s_out_zero_point      <= w.ozp;
        s_alt_mult            <= w.amul;
        s_alt_shift           <= w.ash;
        s_residual_zero_point <= w.rzp;
        s_residual_value      <= w.rv;
        s_valid               <= 1'b1;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        @(negedge aclk);
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Drain the block, let the tail settle, then write the mode
    task automatic set_mode(logic [1:0] mode);
        s_valid <= 1'b0;
        while (results_due != 0) begin
            @(negedge aclk);
        end
        repeat (12) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= mode;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Result side: ready in runs of random length, one long hold-off on request
    initial begin
        int run;
        int gap;
        m_ready = 1'b0;
        @(negedge aclk);
        while (!aresetn) begin
            @(negedge aclk);
        end
        forever begin
            if (hold_request) begin
                m_ready <= 1'b0;
                for (int c = 0; c < 400; c++) begin
                    @(negedge aclk);
                end
                hold_request = 1'b0;
            end else begin
                run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                   : $urandom_range(1, 30);
                m_ready <= 1'b1;
                repeat (run) @(negedge aclk);
                gap = pick_gap();
                if (gap > 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
        end
    end

    // Stimulus
    initial begin
        mac_word_t w;
        int len;
        int sent;
        aresetn               = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = qdr_pkg::MODE_PLAIN;
        s_valid               = 1'b0;
        s_act_value           = '0;
        s_weight_value        = '0;
        s_last_term           = 1'b0;
        s_channel_bias        = '0;
        s_out_mult            = '0;
        s_out_shift           = '0;
        s_out_zero_point      = '0;
        s_alt_mult            = '0;
        s_alt_shift           = '0;
        s_residual_zero_point = '0;
        s_residual_value      = '0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Plain mode from reset: saturation both ways, exact values, rounding ties
        w = random_word(1'b0);
        w.act = -8'sd128; w.wgt = -8'sd128;
        send_word(w);
        w.last = 1'b1; w.bias = 48'sh7FFF_FFFF_FFFF; w.omul = 32'sh7FFF_FFFF;
        w.osh = 5'd0; w.ozp = 8'sd127;
        send_word(w);
        w.act = 8'sd127; w.bias = 48'sh8000_0000_0000; w.osh = 5'd31; w.ozp = -8'sd128;
        send_word(w);
        w.act = 8'sd5; w.wgt = -8'sd3; w.bias = '0; w.omul = 32'sd1; w.osh = 5'd0;
        w.ozp = 8'sd0;
        send_word(w);
        w.act = 8'sd0; w.bias = 48'sd128;
        send_word(w);
        w.bias = -48'sd128;
        send_word(w);
        w.omul = '0; w.ozp = -8'sd77;
        send_word(w);
        w.act = 8'sd1; w.wgt = 8'sd1; w.bias = '0; w.omul = 32'sh8000_0000; w.osh = 5'd31;
        send_word(w);

        // PReLU: negative values at both shift extremes, positive value passes
        set_mode(qdr_pkg::MODE_PRELU);
        w.act = -8'sd1; w.wgt = 8'sd100; w.bias = '0; w.amul = 32'sh7FFF_FFFF;
        w.ash = 5'd31; w.omul = 32'sd1; w.osh = 5'd0; w.ozp = 8'sd0;
        send_word(w);
        w.amul = 32'sh8000_0000; w.ash = 5'd0; w.osh = 5'd31;
        send_word(w);
        w.act = 8'sd10; w.wgt = 8'sd10; w.osh = 5'd0;
        send_word(w);

        // Residual: extreme bytes and multipliers, then a byte that centers to zero
        set_mode(qdr_pkg::MODE_RESIDUAL);
        w.act = 8'sd0; w.rv = -8'sd128; w.rzp = -8'sd128; w.amul = 32'sh8000_0000;
        w.ash = 5'd0; w.osh = 5'd31;
        send_word(w);
        w.rv = 8'sd127; w.rzp = 8'sd127; w.amul = 32'sh7FFF_FFFF; w.ash = 5'd31;
        w.osh = 5'd0; w.ozp = -8'sd128;
        send_word(w);
        w.act = 8'sd9; w.wgt = -8'sd4; w.rv = 8'sd5; w.rzp = -8'sd5; w.ozp = 8'sd3;
        send_word(w);

        // Spare mode code acts as plain
        set_mode(MODE_SPARE);
        w = random_word(1'b1);
        w.act = -8'sd3; w.wgt = 8'sd7; w.omul = 32'sd1; w.osh = 5'd0;
        send_word(w);

        // Long run of full-scale terms, back to back
        set_mode(qdr_pkg::MODE_PLAIN);
        gaps_on = 1'b0;
        w = random_word(1'b0);
        w.act = -8'sd128; w.wgt = -8'sd128;
        for (int i = 0; i < LONG_TERMS; i++) begin
            send_word(w);
        end
        w.last = 1'b1; w.bias = '0; w.omul = 32'sd1; w.osh = 5'd31; w.ozp = 8'sd0;
        send_word(w);
        gaps_on = 1'b1;

        // Random dot products, mostly short, across the modes
        for (int p = 0; p < PHASES; p++) begin
            set_mode(phase_modes[p]);
            gaps_on = (p != 4);
            if (p == 2) begin
                hold_request = 1'b1;
            end
            sent = 0;
            while (sent < WORDS_PER_PHASE) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: len = $urandom_range(1, 4);
                    6, 7, 8:          len = $urandom_range(5, 16);
                    default:          len = $urandom_range(17, 64);
                endcase
                for (int k = 0; k < len; k++) begin
                    send_word(random_word(k == len - 1));
                end
                sent += len;
            end
        end

        // Drain and give the verdict
        s_valid <= 1'b0;
        while (results_due != 0) begin
            @(negedge aclk);
        end
        repeat (20) @(negedge aclk);
        if (mismatch_count == 0 && results_due == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #13_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
